// ----- rtl/bcc_pkg.sv -----
package bcc_pkg;

  // Input item
  typedef struct packed {
    logic        command;
    logic        button_level;
    logic [31:0] now_ms;
  } bcc_in_t;

  // Result item
  typedef struct packed {
    logic signed [4:0] click_report;
    logic              pressed;
    logic              edit_active;
  } bcc_out_t;

  // Input command codes
  localparam logic CMD_SAMPLE    = 1'b0;
  localparam logic CMD_EDIT_MODE = 1'b1;

  // Configuration register indexes
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_ACTIVE_HIGH    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE       = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MULTICLICK     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_EDIT_MULTICLK  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_LONG_CLICK     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_EDIT_TIMEOUT   = 3'd5;

  localparam int CfgDataW = 16;

  // Reset values of the timing registers
  localparam logic [15:0] DEBOUNCE_RST      = 16'd20;
  localparam logic [15:0] MULTICLICK_RST    = 16'd250;
  localparam logic [15:0] EDIT_MULTICLK_RST = 16'd50;
  localparam logic [15:0] LONG_CLICK_RST    = 16'd1000;
  localparam logic [15:0] EDIT_TIMEOUT_RST  = 16'd3000;

  // Press counter saturates at the smaller of MaxClicks and 15
  localparam int MaxClicks = 15;
  localparam logic [3:0] COUNT_LIMIT = (MaxClicks < 15) ? 4'(MaxClicks) : 4'd15;

  // Elapsed time from stamp to now, read as signed, strictly above limit
  function automatic logic elapsed_over(input logic [31:0] now, input logic [31:0] stamp,
                                        input logic [15:0] limit);
    logic [31:0] d;
    d = now - stamp;
    return !d[31] && (d > {16'd0, limit});
  endfunction

endpackage

// ----- rtl/button_click_classifier_unit.sv -----
// Channel  | Direction | Handshake             | Payload
// in       | input     | in_valid / in_ready   | in_data  (bcc_in_t)
// out      | output    | out_valid / out_ready | out_data (bcc_out_t)
// cfg      | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Items pass the input and result registers; one item per cycle while out_ready is high.
// The input register feeds one pass of timer compares that updates the state and the result.
// Reset (rst_n low, synchronous) restores the default timing registers and the state.
// A stalled result holds the result register; the input register moves only when it frees.
// cfg_ready is always high; a write to an unknown index is ignored.
module button_click_classifier_unit import bcc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bcc_in_t             in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bcc_out_t            out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  // Configuration registers
  logic        active_high_r;
  logic [15:0] debounce_r, multiclick_r, edit_multiclk_r, long_click_r, edit_timeout_r;

  // Input register and result register
  logic        s1_valid_r;
  bcc_in_t     s1_data_r;
  logic        out_valid_r;
  bcc_out_t    out_data_r;

  // Detector state
  logic        prev_level_r, prev_level_nxt;
  logic        deb_level_r, deb_level_nxt;
  logic [3:0]  count_r, count_nxt;
  logic [31:0] bounce_time_r, bounce_time_nxt;
  logic [4:0]  report_r, report_nxt;
  logic        edit_r, edit_nxt;
  logic [31:0] edit_start_r, edit_start_nxt;

  logic        s2_load;
  logic        advance;
  logic        level;
  logic [15:0] window;
  logic [3:0]  count_deb;

  assign cfg_ready = 1'b1;
  assign s2_load   = !out_valid_r || out_ready;
  assign advance   = s1_valid_r && s2_load;
  assign in_ready  = !s1_valid_r || s2_load;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_high_r   <= 1'b0;
      debounce_r      <= DEBOUNCE_RST;
      multiclick_r    <= MULTICLICK_RST;
      edit_multiclk_r <= EDIT_MULTICLK_RST;
      long_click_r    <= LONG_CLICK_RST;
      edit_timeout_r  <= EDIT_TIMEOUT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ACTIVE_HIGH:   active_high_r   <= cfg_data[0];
        REG_DEBOUNCE:      debounce_r      <= cfg_data;
        REG_MULTICLICK:    multiclick_r    <= cfg_data;
        REG_EDIT_MULTICLK: edit_multiclk_r <= cfg_data;
        REG_LONG_CLICK:    long_click_r    <= cfg_data;
        REG_EDIT_TIMEOUT:  edit_timeout_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  // One pass: edit command, or bounce timer, debounce, group end, long click, edit timeout
  always_comb begin
    prev_level_nxt  = prev_level_r;
    deb_level_nxt   = deb_level_r;
    count_nxt       = count_r;
    bounce_time_nxt = bounce_time_r;
    report_nxt      = report_r;
    edit_nxt        = edit_r;
    edit_start_nxt  = edit_start_r;
    level           = active_high_r ? s1_data_r.button_level : !s1_data_r.button_level;
    window          = edit_r ? edit_multiclk_r : multiclick_r;
    count_deb       = count_r;

    if (s1_data_r.command == CMD_EDIT_MODE) begin
      edit_nxt       = 1'b1;
      edit_start_nxt = s1_data_r.now_ms;
    end else begin
      if (level != prev_level_r) begin
        bounce_time_nxt = s1_data_r.now_ms;
      end
      if (elapsed_over(s1_data_r.now_ms, bounce_time_nxt, debounce_r)
          && level != deb_level_r) begin
        deb_level_nxt = level;
        if (level && count_r < COUNT_LIMIT) begin
          count_deb = count_r + 4'd1;
        end
      end
      count_nxt = count_deb;
      if (!deb_level_nxt && elapsed_over(s1_data_r.now_ms, bounce_time_nxt, window)) begin
        report_nxt = {1'b0, count_deb};
        count_nxt  = 4'd0;
      end
      if (deb_level_nxt && elapsed_over(s1_data_r.now_ms, bounce_time_nxt, long_click_r)) begin
        report_nxt = 5'd0 - {1'b0, count_deb};
        count_nxt  = 4'd0;
      end
      if (edit_r && elapsed_over(s1_data_r.now_ms, edit_start_r, edit_timeout_r)) begin
        edit_nxt = 1'b0;
      end
      prev_level_nxt = level;
    end
  end

  // Commit state and the result on each advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r  <= 1'b1;
      deb_level_r   <= 1'b0;
      count_r       <= 4'd0;
      bounce_time_r <= 32'd0;
      report_r      <= 5'd0;
      edit_r        <= 1'b0;
      edit_start_r  <= 32'd0;
    end else if (advance) begin
      prev_level_r  <= prev_level_nxt;
      deb_level_r   <= deb_level_nxt;
      count_r       <= count_nxt;
      bounce_time_r <= bounce_time_nxt;
      report_r      <= report_nxt;
      edit_r        <= edit_nxt;
      edit_start_r  <= edit_start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r.click_report <= signed'(report_nxt);
      out_data_r.pressed      <= deb_level_nxt;
      out_data_r.edit_active  <= edit_nxt;
    end
  end

  // Press counter never passes its limit
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_LIMIT)
    else $error("press counter above limit");

  // Report stays within the signed range of the count
  a_report_range: assert property (@(posedge clk) disable iff (!rst_n)
    report_r != 5'b10000)
    else $error("report value out of range");

  // Edit command turns edit mode on
  a_edit_on: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_data_r.command == CMD_EDIT_MODE |=> edit_r && out_data_r.edit_active)
    else $error("edit command did not enter edit mode");

  // Result mirrors the committed state
  a_result_state: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_data_r.pressed == deb_level_r
                && out_data_r.click_report == signed'(report_r))
    else $error("result differs from state");

  // A stalled item stays in the input register and the result stays valid
  a_no_lost_item: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_load |=> s1_valid_r && out_valid_r)
    else $error("item dropped under stall");

endmodule

// ----- verif/tb_button_click_classifier_unit.sv -----
`timescale 1ns / 100ps

module tb_button_click_classifier_unit;
  import bcc_pkg::*;

  // Indexes outside the register map; writes to them must be ignored
  localparam logic [CfgIdxW-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_UNMAPPED_HI = 3'd7;

  typedef enum {RX_FREE, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_ready;
  bcc_in_t             in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  bcc_out_t            out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  button_click_classifier_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register shadows, at their reset values
  logic        cfg_act_high = 1'b0;
  logic [15:0] cfg_debounce = DEBOUNCE_RST;
  logic [15:0] cfg_win      = MULTICLICK_RST;
  logic [15:0] cfg_edit_win = EDIT_MULTICLK_RST;
  logic [15:0] cfg_long     = LONG_CLICK_RST;
  logic [15:0] cfg_edit_to  = EDIT_TIMEOUT_RST;

  // Classifier state, at its reset values
  logic        prev_lvl     = 1'b1;
  logic        deb_lvl      = 1'b0;
  logic [3:0]  presses      = 4'd0;
  logic [31:0] bounce_stamp = 32'd0;
  logic [4:0]  held_report  = 5'd0;
  logic        edit_on      = 1'b0;
  logic [31:0] edit_stamp   = 32'd0;

  bcc_in_t  sample_queue[$];
  bcc_out_t expected_reports[$];
  bcc_out_t oldest_report;
  int       mismatch_count = 0;
  int       items_made = 0;
  logic     in_taken = 1'b0;
  logic [31:0] ms_now = 32'd0;

  int       burst_left = 0;
  int       gap_left = 0;
  rx_mode_t rx_mode = RX_FREE;
  int       rx_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Elapsed time read as signed; passes only when strictly above the limit
  function automatic bit span_exceeds(logic [31:0] now, logic [31:0] stamp, logic [15:0] lim);
    logic signed [31:0] delta;
    delta = $signed(now - stamp);
    return delta > $signed({16'd0, lim});
  endfunction

  // Advance the classifier by one item and return the result it shows
  function automatic bcc_out_t classify_item(bcc_in_t item);
    bcc_out_t    res;
    logic        lvl;
    logic [15:0] win;
    if (item.command == CMD_EDIT_MODE) begin
      edit_on = 1'b1;
      edit_stamp = item.now_ms;
    end else begin
      lvl = cfg_act_high ? item.button_level : ~item.button_level;
      win = edit_on ? cfg_edit_win : cfg_win;
      if (lvl != prev_lvl) bounce_stamp = item.now_ms;
      if (span_exceeds(item.now_ms, bounce_stamp, cfg_debounce) && lvl != deb_lvl) begin
        deb_lvl = lvl;
        if (deb_lvl && presses < COUNT_LIMIT) presses = presses + 4'd1;
      end
      // group end while released, long click while held
      if (!deb_lvl && span_exceeds(item.now_ms, bounce_stamp, win)) begin
        held_report = {1'b0, presses};
        presses = 4'd0;
      end
      if (deb_lvl && span_exceeds(item.now_ms, bounce_stamp, cfg_long)) begin
        held_report = 5'd0 - {1'b0, presses};
        presses = 4'd0;
      end
      if (edit_on && span_exceeds(item.now_ms, edit_stamp, cfg_edit_to)) edit_on = 1'b0;
      prev_lvl = lvl;
    end
    res.click_report = held_report;
    res.pressed = deb_lvl;
    res.edit_active = edit_on;
    return res;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    if (mismatch_count < 40) $display("%0t ns %s: got %0d want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Driver: bursts of transfers separated by random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (burst_left != 0 && sample_queue.size() != 0) begin
        in_data <= sample_queue.pop_front();
        in_valid <= 1'b1;
        burst_left <= burst_left - 1;
      end else begin
        in_valid <= 1'b0;
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
        end else begin
          burst_left <= $urandom_range(1, 60);
          gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 3);
        end
      end
    end
  end

  // Receiver: stall pattern that changes character every so often
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(8, 150);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_FREE:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:   out_ready <= (rx_left % 16 == 0);
    endcase
  end

  // Monitor: predict on each input transfer, check each result transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) expected_reports.push_back(classify_item(in_data));
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          flag_mismatch("result with nothing expected", 0, 0);
        end else begin
          oldest_report = expected_reports.pop_front();
          if (out_data.click_report !== oldest_report.click_report)
            flag_mismatch("click_report", int'($signed(out_data.click_report)),
                          int'($signed(oldest_report.click_report)));
          if (out_data.pressed !== oldest_report.pressed)
            flag_mismatch("pressed", int'(out_data.pressed), int'(oldest_report.pressed));
          if (out_data.edit_active !== oldest_report.edit_active)
            flag_mismatch("edit_active", int'(out_data.edit_active),
                          int'(oldest_report.edit_active));
        end
      end
    end
  end

  task automatic push_item(logic cmd, logic raw, logic [31:0] stamp);
    bcc_in_t item;
    item.command = cmd;
    item.button_level = raw;
    item.now_ms = stamp;
    sample_queue.push_back(item);
    items_made++;
  endtask

  // Advance the time line and queue a sample of the given pressed state
  task automatic push_sample(bit pressed_lvl, int unsigned dt);
    ms_now = ms_now + dt;
    push_item(CMD_SAMPLE, cfg_act_high ? pressed_lvl : !pressed_lvl, ms_now);
  endtask

  function automatic int unsigned at_least_one(int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  // Bounce a little, then hold the level until the span has passed
  task automatic level_run(bit lvl, int unsigned span);
    int unsigned spent;
    int unsigned step;
    repeat ($urandom_range(0, 2)) begin
      push_sample(lvl, $urandom_range(0, cfg_debounce));
      push_sample(!lvl, $urandom_range(0, cfg_debounce));
    end
    push_sample(lvl, $urandom_range(0, cfg_debounce));
    spent = 0;
    while (spent <= span) begin
      step = $urandom_range(1, span / 2 + 1);
      push_sample(lvl, step);
      spent += step;
    end
  endtask

  task automatic click_group(int unsigned clicks);
    int unsigned short_win;
    int unsigned long_win;
    short_win = (cfg_win < cfg_edit_win) ? cfg_win : cfg_edit_win;
    long_win = (cfg_win < cfg_edit_win) ? cfg_edit_win : cfg_win;
    for (int i = 0; i < clicks; i++) begin
      level_run(1'b1, cfg_debounce + $urandom_range(1, at_least_one(cfg_long / 2)));
      if (i != clicks - 1)
        level_run(1'b0, cfg_debounce + $urandom_range(1, at_least_one(short_win / 4)));
    end
    level_run(1'b0, cfg_debounce + long_win + $urandom_range(1, 20));
    if ($urandom_range(0, 1)) push_sample(1'b0, $urandom_range(1, 10));
  endtask

  task automatic long_press();
    level_run(1'b1, cfg_debounce + cfg_long + $urandom_range(1, 30));
    repeat ($urandom_range(0, 2)) push_sample(1'b1, $urandom_range(1, 10));
    level_run(1'b0, cfg_debounce + $urandom_range(1, at_least_one(cfg_win)));
  endtask

  // Random levels, edit commands, far jumps and steps back in time
  task automatic noise_burst();
    int unsigned dt;
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 3))
        0:       dt = $urandom_range(0, 3);
        1:       dt = $urandom_range(0, 2 * cfg_debounce + 2);
        2:       dt = $urandom();
        default: dt = 0 - $urandom_range(1, 500);
      endcase
      if ($urandom_range(0, 5) == 0) begin
        ms_now = ms_now + dt;
        push_item(CMD_EDIT_MODE, 1'($urandom_range(0, 1)), ms_now);
      end else begin
        push_sample(1'($urandom_range(0, 1)), dt);
      end
    end
  endtask

  task automatic random_phase(int count);
    int target;
    int pick;
    target = items_made + count;
    while (items_made < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        if ($urandom_range(0, 7) == 0) click_group($urandom_range(14, 17));
        else click_group($urandom_range(1, 4));
      end else if (pick < 70) begin
        long_press();
      end else if (pick < 82) begin
        ms_now = ms_now + $urandom_range(0, 5);
        push_item(CMD_EDIT_MODE, 1'($urandom_range(0, 1)), ms_now);
      end else begin
        noise_burst();
      end
    end
  endtask

  // Hold off until every queued item has been checked and the pipe is empty
  task automatic drain();
    while (sample_queue.size() != 0 || in_valid || expected_reports.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ACTIVE_HIGH:   cfg_act_high = val[0];
      REG_DEBOUNCE:      cfg_debounce = val;
      REG_MULTICLICK:    cfg_win = val;
      REG_EDIT_MULTICLK: cfg_edit_win = val;
      REG_LONG_CLICK:    cfg_long = val;
      REG_EDIT_TIMEOUT:  cfg_edit_to = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(logic [15:0] ah, logic [15:0] deb, logic [15:0] win,
                               logic [15:0] ewin, logic [15:0] lng, logic [15:0] eto);
    write_reg(REG_ACTIVE_HIGH, ah);
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_MULTICLICK, win);
    write_reg(REG_EDIT_MULTICLK, ewin);
    write_reg(REG_LONG_CLICK, lng);
    write_reg(REG_EDIT_TIMEOUT, eto);
  endtask

  // Directed items at the reset timing (active-low, 20/250/50/1000/3000)
  task automatic directed_items();
    push_item(CMD_SAMPLE, 1'b1, 32'd0);
    push_item(CMD_EDIT_MODE, 1'b0, 32'd5);
    // entering edit mode again restarts the timeout
    push_item(CMD_EDIT_MODE, 1'b1, 32'd7);
    // one click, group ended by the edit window, then the report falls to zero
    push_item(CMD_SAMPLE, 1'b0, 32'd10);
    push_item(CMD_SAMPLE, 1'b0, 32'd31);
    push_item(CMD_SAMPLE, 1'b1, 32'd40);
    push_item(CMD_SAMPLE, 1'b1, 32'd61);
    push_item(CMD_SAMPLE, 1'b1, 32'd91);
    push_item(CMD_SAMPLE, 1'b1, 32'd92);
    push_item(CMD_EDIT_MODE, 1'b0, 32'd2000);
    push_item(CMD_SAMPLE, 1'b0, 32'd4000);
    push_item(CMD_SAMPLE, 1'b0, 32'd4021);
    push_item(CMD_SAMPLE, 1'b0, 32'd4030);
    // group end by the edit window in the same step that edit mode times out
    push_item(CMD_SAMPLE, 1'b1, 32'd4940);
    push_item(CMD_SAMPLE, 1'b1, 32'd4961);
    push_item(CMD_SAMPLE, 1'b1, 32'd5001);
    // long click, then a repeated report of zero
    push_item(CMD_SAMPLE, 1'b0, 32'd5010);
    push_item(CMD_SAMPLE, 1'b0, 32'd5031);
    push_item(CMD_SAMPLE, 1'b0, 32'd6011);
    push_item(CMD_SAMPLE, 1'b0, 32'd6012);
    // time steps backwards: negative elapsed never passes
    push_item(CMD_SAMPLE, 1'b0, 32'd5000);
    // wrap of the timestamp
    push_item(CMD_SAMPLE, 1'b1, 32'hFFFF_FFF0);
    push_item(CMD_EDIT_MODE, 1'b1, 32'hFFFF_FFFF);
    push_item(CMD_SAMPLE, 1'b1, 32'h0000_0010);
    push_item(CMD_SAMPLE, 1'b1, 32'h8000_0020);
    ms_now = 32'h8000_0020;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    directed_items();
    random_phase(260);
    drain();

    apply_setting(16'd1, 16'd3, 16'd40, 16'd10, 16'd120, 16'd400);
    random_phase(300);
    drain();

    apply_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    random_phase(200);
    drain();

    apply_setting(16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_phase(200);
    drain();

    write_reg(REG_UNMAPPED_LO, 16'($urandom_range(0, 16'hFFFF)));
    write_reg(REG_UNMAPPED_HI, 16'($urandom_range(0, 16'hFFFF)));
    apply_setting(16'($urandom_range(0, 1)), 16'($urandom_range(0, 60)),
                  16'($urandom_range(0, 400)), 16'($urandom_range(0, 150)),
                  16'($urandom_range(0, 1500)), 16'($urandom_range(0, 5000)));
    random_phase(300);
    drain();

    apply_setting(16'($urandom_range(0, 1)), 16'($urandom_range(0, 60)),
                  16'($urandom_range(0, 400)), 16'($urandom_range(0, 150)),
                  16'($urandom_range(0, 1500)), 16'($urandom_range(0, 5000)));
    random_phase(300);
    drain();

    if (mismatch_count == 0) begin
      $display("button_click_classifier_unit: match");
    end else begin
      $display("button_click_classifier_unit: mismatch");
    end
    $finish;
  end

  // Give up on a hung handshake
  initial begin
    #5_000_000;
    $display("button_click_classifier_unit: mismatch");
    $finish;
  end

endmodule
